@@ sv/e3ss_pkg.sv @@
// Shared types, constants and helper functions of the Exp3 strategy selector.
package e3ss_pkg;

    localparam int NUM_STRATEGIES_DEF = 4;

    // Stream and configuration widths
    localparam int S_TDATA_W  = 104;
    localparam int M_TDATA_W  = 24;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAXV = 1'b1;

    localparam logic [15:0] GAIN_RST = 16'd6554;
    localparam logic [31:0] MAXV_RST = 32'd65536;

    // Request kinds
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    // Fixed-point constants
    localparam logic [31:0] CAP32    = 32'hFFFF_FFFF;
    localparam logic [31:0] ARG_CAP  = 32'h0010_0000;
    localparam logic [31:0] L2E_Q30  = 32'd1549082005;
    localparam logic [31:0] LN2_Q30  = 32'd744261118;
    localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [3:0]  TAYLOR_TERMS = 4'd12;

    // Divider geometry
    localparam int DIV_NUM_W = 96;
    localparam int DIV_DEN_W = 64;
    localparam int DIV_CNT_W = 7;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = 7'(DIV_NUM_W - 1);

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
        logic [31:0]          cap;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
    } div_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_S_SUM,
        ST_S_MLO,
        ST_S_MHI,
        ST_S_TGT,
        ST_S_SCAN,
        ST_S_PICK,
        ST_U_CNT,
        ST_U_DEN,
        ST_U_XDIV,
        ST_E_Y,
        ST_E_K,
        ST_E_V,
        ST_E_TM,
        ST_E_TR,
        ST_E_TF,
        ST_W_MUL,
        ST_W_SH,
        ST_T_SUM,
        ST_WN_DIV,
        ST_B_MUL,
        ST_B_ADD,
        ST_F_DIV,
        ST_Q_MUL,
        ST_Q_ST,
        ST_P_DIV,
        ST_U_RES,
        ST_DONE
    } state_t;

    // ceil(2^32 / n) for the Taylor term divisors two to twelve
    function automatic logic [31:0] recip_q32(input logic [3:0] n);
        logic [31:0] r;
        unique case (n)
            4'd2:    r = 32'd2147483648;
            4'd3:    r = 32'd1431655766;
            4'd4:    r = 32'd1073741824;
            4'd5:    r = 32'd858993460;
            4'd6:    r = 32'd715827883;
            4'd7:    r = 32'd613566757;
            4'd8:    r = 32'd536870912;
            4'd9:    r = 32'd477218589;
            4'd10:   r = 32'd429496730;
            4'd11:   r = 32'd390451573;
            4'd12:   r = 32'd357913942;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

@@ sv/e3ss_div.sv @@
// Bit-serial restoring divider: min(cap, floor(num / den)), one quotient bit per cycle.
module e3ss_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  e3ss_pkg::div_req_t req,
    output e3ss_pkg::div_rsp_t rsp
);
    import e3ss_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_NUM_W-1:0] num_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [31:0]          cap_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [31:0]          quo_reg;
    logic                 ovf_reg;
    logic                 num_zero_reg;
    logic [31:0]          res_reg;

    logic [DIV_DEN_W:0]   rem_sh;
    logic                 fits;
    logic [DIV_DEN_W:0]   rem_sub;
    logic [31:0]          quo_new;
    logic                 ovf_new;
    logic                 sat;

    always_comb begin
        rem_sh  = {rem_reg, num_reg[DIV_NUM_W-1]};
        fits    = rem_sh >= {1'b0, den_reg};
        rem_sub = fits ? (rem_sh - {1'b0, den_reg}) : rem_sh;
        quo_new = {quo_reg[30:0], fits};
        ovf_new = ovf_reg | quo_reg[31];
        sat     = ovf_new || (quo_new > cap_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg     <= 1'b1;
                cnt_reg      <= '0;
                num_reg      <= req.num;
                den_reg      <= req.den;
                cap_reg      <= req.cap;
                num_zero_reg <= (req.num == '0);
                rem_reg      <= '0;
                quo_reg      <= '0;
                ovf_reg      <= 1'b0;
            end else if (busy_reg) begin
                rem_reg <= rem_sub[DIV_DEN_W-1:0];
                quo_reg <= quo_new;
                ovf_reg <= ovf_new;
                num_reg <= {num_reg[DIV_NUM_W-2:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    if (den_reg == '0) begin
                        res_reg <= num_zero_reg ? 32'd0 : cap_reg;
                    end else begin
                        res_reg <= sat ? cap_reg : quo_new;
                    end
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = res_reg;

endmodule

@@ sv/exp3_strategy_selector_core.sv @@
// Exp3 bandit strategy selector: sampling and weight update over one shared multiplier and divider.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------------
//  s_      | in        | s_tvalid / s_tready | tuser: req_type; tdata: request fields
//  m_      | out       | m_tvalid / m_tready | tuser: none_left; tdata: index, probability
//  cfg_    | in        | cfg_wr_en           | cfg_addr selects gain or max value
//
//  A sample makes one pass over the strategies to sum the allowed probabilities, two
//  products for the target and one pass to find the pick. An update runs 3*N+1 divisions
//  on the bit-serial divider.
//  Reset clears counters, restores uniform weights and probabilities and empties the output.
//  s_tready is high only while the sequencer is idle; a result waiting on m_tready holds the
//  sequencer in its final state while the output register is full.
module exp3_strategy_selector_core #(
    parameter int NUM_STRATEGIES = e3ss_pkg::NUM_STRATEGIES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [e3ss_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [e3ss_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // exclude_mask[3:0], random_fraction[35:4], strategy_index[37:36],
    // time_used[69:38], delta_q[101:70], zero[103:102]
    input  logic [e3ss_pkg::S_TDATA_W-1:0]  s_tdata,
    // req_type[0]
    input  logic [0:0]                      s_tuser,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // chosen_index[1:0], chosen_probability[17:2], zero[23:18]
    output logic [e3ss_pkg::M_TDATA_W-1:0]  m_tdata,
    // none_left[0]
    output logic [0:0]                      m_tuser
);
    import e3ss_pkg::*;

    localparam int IW  = $clog2(NUM_STRATEGIES);
    localparam int SW  = 32 + IW;
    localparam int QSW = 56 + IW;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_STRATEGIES - 1);
    localparam logic [31:0] UNIFORM_SHARE = 32'(64'h1_0000_0000 / NUM_STRATEGIES);

    // ---------------------------------------------------------------- request fields
    logic [3:0]  in_mask;
    logic [31:0] in_rand;
    logic [1:0]  in_idx;
    logic [31:0] in_time;
    logic [31:0] in_dq;
    logic        in_accept;
    logic        in_idx_ok;
    logic [NUM_STRATEGIES-1:0] in_excl;

    assign in_mask   = s_tdata[3:0];
    assign in_rand   = s_tdata[35:4];
    assign in_idx    = s_tdata[37:36];
    assign in_time   = s_tdata[69:38];
    assign in_dq     = s_tdata[101:70];
    assign in_accept = s_tvalid && s_tready;
    assign in_idx_ok = 32'(in_idx) < NUM_STRATEGIES;

    // only the first four strategies can be excluded
    for (genvar gi = 0; gi < NUM_STRATEGIES; gi++) begin : g_excl
        if (gi < 4) begin : g_bit
            assign in_excl[gi] = in_mask[gi];
        end else begin : g_none
            assign in_excl[gi] = 1'b0;
        end
    end

    // ---------------------------------------------------------------- registers
    state_t state_reg, state_next;

    logic [15:0] gain_reg;
    logic [31:0] maxv_reg;

    logic [31:0] weight_reg [NUM_STRATEGIES];
    logic [31:0] prob_reg   [NUM_STRATEGIES];
    logic [31:0] uc_reg     [NUM_STRATEGIES];
    logic [47:0] ts_reg     [NUM_STRATEGIES];
    logic [55:0] qv_reg     [NUM_STRATEGIES];

    logic [NUM_STRATEGIES-1:0] excl_reg;
    logic [31:0] rand_reg;
    logic [31:0] time_reg;
    logic [30:0] dq_reg;
    logic [IW-1:0] s_reg;
    logic [IW-1:0] ptr_reg;
    logic [IW-1:0] first_reg;
    logic        found_reg;
    logic [SW-1:0] sum_reg;
    logic [SW-1:0] tgt_reg;
    logic [SW-1:0] cum_reg;
    logic [46:0] gd_reg;
    logic [20:0] x_reg;
    logic [4:0]  k_reg;
    logic [29:0] v_reg;
    logic [30:0] term_reg;
    logic [31:0] mant_reg;
    logic [29:0] t_reg;
    logic [3:0]  n_reg;
    logic [63:0] fullw_reg;
    logic [63:0] total_reg;
    logic [31:0] base_reg;
    logic [31:0] f_reg;
    logic [QSW-1:0] qsum_reg;
    logic        div_wait_reg;
    logic [63:0] mul_p_reg;

    logic [1:0]  res_idx_reg;
    logic        res_none_reg;
    logic [15:0] res_prob_reg;

    logic        m_tvalid_reg;
    logic [1:0]  out_idx_reg;
    logic        out_none_reg;
    logic [15:0] out_prob_reg;

    // ---------------------------------------------------------------- shared units
    logic        mul_en;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    div_req_t    div_req;
    div_rsp_t    div_rsp;

    e3ss_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            mul_p_reg <= 64'(mul_a) * 64'(mul_b);
        end
    end

    // ---------------------------------------------------------------- helpers
    logic          ptr_last;
    logic          excl_ptr;
    logic [31:0]   prob_ptr;
    logic [31:0]   ptr_wide;
    logic [SW-1:0] cum_add;
    logic          hit;
    logic [63:0]   full_ptr;
    logic [4:0]    k_clamp;
    logic [4:0]    w_shift;
    logic [29:0]   qd;
    logic [33:0]   qd_n;
    logic [29:0]   qd_fix;
    logic [15:0]   gain_neg;
    logic [32:0]   base_raw;
    logic [48:0]   ts_sum;
    logic          div_done;

    always_comb begin
        ptr_last = (ptr_reg == LAST_IDX);
        excl_ptr = excl_reg[ptr_reg];
        prob_ptr = prob_reg[ptr_reg];
        ptr_wide = 32'(ptr_reg);
        cum_add  = cum_reg + SW'(prob_ptr);
        hit      = !excl_ptr && (tgt_reg < cum_add);
        full_ptr = (ptr_reg == s_reg) ? fullw_reg : 64'(weight_reg[ptr_reg]);
        k_clamp  = (k_reg > 5'd30) ? 5'd30 : k_reg;
        w_shift  = 5'd30 - k_clamp;
        qd       = mul_p_reg[61:32];
        qd_n     = 34'(qd) * 34'(n_reg);
        // reciprocal estimate is at most one high
        qd_fix   = (qd_n > 34'(t_reg)) ? (qd - 30'd1) : qd;
        gain_neg = 16'(17'h1_0000 - 17'(gain_reg));
        base_raw = ((gain_reg == 16'd0) ? 33'(weight_reg[ptr_reg]) : 33'(mul_p_reg[47:16]))
                   + 33'({gain_reg, 15'd0});
        ts_sum   = 49'(ts_reg[ptr_reg]) + 49'(time_reg);
        div_done = div_rsp.done;
    end

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        mul_en        = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = '0;
        div_req.cap   = CAP32;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (s_tuser[0] == REQ_SAMPLE) begin
                        state_next = ST_S_SUM;
                    end else if (!in_idx_ok) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_U_CNT;
                    end
                end
            end
            ST_S_SUM: begin
                if (ptr_last) begin
                    state_next = (!found_reg && excl_ptr) ? ST_DONE : ST_S_MLO;
                end
            end
            ST_S_MLO: begin
                mul_en     = 1'b1;
                mul_a      = rand_reg;
                mul_b      = sum_reg[31:0];
                state_next = ST_S_MHI;
            end
            ST_S_MHI: begin
                mul_en     = 1'b1;
                mul_a      = rand_reg;
                mul_b      = 32'(sum_reg >> 32);
                state_next = ST_S_TGT;
            end
            ST_S_TGT: begin
                state_next = ST_S_SCAN;
            end
            ST_S_SCAN: begin
                if (hit) begin
                    state_next = ST_DONE;
                end else if (ptr_last) begin
                    state_next = ST_S_PICK;
                end
            end
            ST_S_PICK: begin
                state_next = ST_DONE;
            end
            ST_U_CNT: begin
                mul_en     = 1'b1;
                mul_a      = 32'(gain_reg);
                mul_b      = 32'(dq_reg);
                state_next = ST_U_DEN;
            end
            ST_U_DEN: begin
                mul_en     = 1'b1;
                mul_a      = maxv_reg;
                mul_b      = prob_ptr;
                state_next = ST_U_XDIV;
            end
            ST_U_XDIV: begin
                div_req.start = !div_wait_reg;
                div_req.num   = {18'd0, gd_reg, 31'd0};
                div_req.den   = mul_p_reg;
                div_req.cap   = ARG_CAP;
                if (div_done) begin
                    state_next = ST_E_Y;
                end
            end
            ST_E_Y: begin
                mul_en     = 1'b1;
                mul_a      = 32'(x_reg);
                mul_b      = L2E_Q30;
                state_next = ST_E_K;
            end
            ST_E_K: begin
                mul_en     = 1'b1;
                mul_a      = 32'(mul_p_reg[45:16]);
                mul_b      = LN2_Q30;
                state_next = ST_E_V;
            end
            ST_E_V: begin
                state_next = ST_E_TM;
            end
            ST_E_TM: begin
                mul_en     = 1'b1;
                mul_a      = 32'(term_reg);
                mul_b      = 32'(v_reg);
                state_next = ST_E_TR;
            end
            ST_E_TR: begin
                if (n_reg == 4'd1) begin
                    state_next = ST_E_TM;
                end else begin
                    mul_en     = 1'b1;
                    mul_a      = 32'(mul_p_reg[59:30]);
                    mul_b      = recip_q32(n_reg);
                    state_next = ST_E_TF;
                end
            end
            ST_E_TF: begin
                state_next = (n_reg == TAYLOR_TERMS) ? ST_W_MUL : ST_E_TM;
            end
            ST_W_MUL: begin
                mul_en     = 1'b1;
                mul_a      = weight_reg[ptr_reg];
                mul_b      = mant_reg;
                state_next = ST_W_SH;
            end
            ST_W_SH: begin
                state_next = ST_T_SUM;
            end
            ST_T_SUM: begin
                if (ptr_last) begin
                    state_next = ST_WN_DIV;
                end
            end
            ST_WN_DIV: begin
                div_req.start = !div_wait_reg;
                div_req.num   = {full_ptr, 32'd0};
                div_req.den   = total_reg;
                if (div_done && ptr_last) begin
                    state_next = ST_B_MUL;
                end
            end
            ST_B_MUL: begin
                mul_en     = 1'b1;
                mul_a      = 32'(gain_neg);
                mul_b      = weight_reg[ptr_reg];
                state_next = ST_B_ADD;
            end
            ST_B_ADD: begin
                state_next = ST_F_DIV;
            end
            ST_F_DIV: begin
                div_req.start = !div_wait_reg;
                div_req.num   = {31'd0, 33'(uc_reg[ptr_reg]) + 33'd1, 32'd0};
                div_req.den   = 64'(ts_reg[ptr_reg]) + 64'd65536;
                if (div_done) begin
                    state_next = ST_Q_MUL;
                end
            end
            ST_Q_MUL: begin
                mul_en     = 1'b1;
                mul_a      = base_reg;
                mul_b      = f_reg;
                state_next = ST_Q_ST;
            end
            ST_Q_ST: begin
                state_next = ptr_last ? ST_P_DIV : ST_B_MUL;
            end
            ST_P_DIV: begin
                if (qsum_reg == '0) begin
                    state_next = ST_U_RES;
                end else begin
                    div_req.start = !div_wait_reg;
                    div_req.num   = {8'd0, qv_reg[ptr_reg], 32'd0};
                    div_req.den   = 64'(qsum_reg);
                    if (div_done && ptr_last) begin
                        state_next = ST_U_RES;
                    end
                end
            end
            ST_U_RES: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= GAIN_RST;
            maxv_reg <= MAXV_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_GAIN: gain_reg <= cfg_wdata[15:0];
                CFG_MAXV: maxv_reg <= cfg_wdata;
                default:  gain_reg <= gain_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------- divider handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_wait_reg <= 1'b0;
        end else if (div_req.start) begin
            div_wait_reg <= 1'b1;
        end else if (div_done) begin
            div_wait_reg <= 1'b0;
        end
    end

    // ---------------------------------------------------------------- strategy state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_STRATEGIES; i++) begin
                weight_reg[i] <= UNIFORM_SHARE;
                prob_reg[i]   <= UNIFORM_SHARE;
                uc_reg[i]     <= '0;
                ts_reg[i]     <= '0;
            end
        end else begin
            unique case (state_reg)
                ST_U_CNT: begin
                    // charge the time and count the use, both saturating
                    ts_reg[ptr_reg] <= ts_sum[48] ? TIME_MAX : ts_sum[47:0];
                    if (uc_reg[ptr_reg] != CAP32) begin
                        uc_reg[ptr_reg] <= uc_reg[ptr_reg] + 32'd1;
                    end
                end
                ST_WN_DIV: begin
                    if (div_done) begin
                        weight_reg[ptr_reg] <= div_rsp.quot;
                    end
                end
                ST_P_DIV: begin
                    if (qsum_reg == '0) begin
                        for (int i = 0; i < NUM_STRATEGIES; i++) begin
                            prob_reg[i] <= UNIFORM_SHARE;
                        end
                    end else if (div_done) begin
                        prob_reg[ptr_reg] <= div_rsp.quot;
                    end
                end
                default: begin
                    prob_reg[0] <= prob_reg[0];
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- loop index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        ptr_reg <= (s_tuser[0] == REQ_UPDATE && in_idx_ok) ? IW'(in_idx) : '0;
                    end
                end
                ST_S_SUM, ST_T_SUM: begin
                    ptr_reg <= ptr_last ? '0 : ptr_reg + 1'b1;
                end
                // restart the pass from the first strategy
                ST_S_TGT, ST_W_SH: ptr_reg <= '0;
                ST_S_SCAN: begin
                    if (!hit) begin
                        ptr_reg <= ptr_last ? first_reg : ptr_reg + 1'b1;
                    end
                end
                ST_WN_DIV: begin
                    if (div_done) begin
                        ptr_reg <= ptr_last ? '0 : ptr_reg + 1'b1;
                    end
                end
                ST_Q_ST: begin
                    ptr_reg <= ptr_last ? '0 : ptr_reg + 1'b1;
                end
                ST_P_DIV: begin
                    if (qsum_reg == '0) begin
                        ptr_reg <= s_reg;
                    end else if (div_done) begin
                        ptr_reg <= ptr_last ? s_reg : ptr_reg + 1'b1;
                    end
                end
                default: ptr_reg <= ptr_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------- working registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    excl_reg     <= in_excl;
                    rand_reg     <= in_rand;
                    time_reg     <= in_time;
                    // a negative gain counts as zero
                    dq_reg       <= in_dq[31] ? 31'd0 : in_dq[30:0];
                    s_reg        <= IW'(in_idx);
                    sum_reg      <= '0;
                    found_reg    <= 1'b0;
                    res_idx_reg  <= (s_tuser[0] == REQ_SAMPLE) ? 2'd0 : in_idx;
                    res_none_reg <= 1'b0;
                    res_prob_reg <= '0;
                end
            end
            ST_S_SUM: begin
                if (!excl_ptr) begin
                    sum_reg <= sum_reg + SW'(prob_ptr);
                    if (!found_reg) begin
                        first_reg <= ptr_reg;
                        found_reg <= 1'b1;
                    end
                end
                if (ptr_last && !found_reg && excl_ptr) begin
                    res_idx_reg  <= 2'd0;
                    res_none_reg <= 1'b1;
                    res_prob_reg <= '0;
                end
            end
            ST_S_MHI: tgt_reg <= SW'(mul_p_reg[63:32]);
            ST_S_TGT: begin
                tgt_reg <= tgt_reg + mul_p_reg[SW-1:0];
                cum_reg <= '0;
            end
            ST_S_SCAN: begin
                if (!excl_ptr) begin
                    cum_reg <= cum_add;
                end
                if (hit) begin
                    res_idx_reg  <= ptr_wide[1:0];
                    res_prob_reg <= prob_ptr[31:16];
                end
            end
            ST_S_PICK, ST_U_RES: begin
                res_idx_reg  <= (state_reg == ST_S_PICK) ? ptr_wide[1:0] : res_idx_reg;
                res_prob_reg <= prob_ptr[31:16];
            end
            ST_U_DEN: gd_reg <= mul_p_reg[46:0];
            ST_U_XDIV: begin
                if (div_done) begin
                    x_reg <= div_rsp.quot[20:0];
                end
            end
            ST_E_K: k_reg <= mul_p_reg[50:46];
            ST_E_V: begin
                v_reg    <= mul_p_reg[59:30];
                term_reg <= 31'h4000_0000;
                mant_reg <= 32'h4000_0000;
                n_reg    <= 4'd1;
            end
            ST_E_TR: begin
                if (n_reg == 4'd1) begin
                    term_reg <= 31'(mul_p_reg[59:30]);
                    mant_reg <= mant_reg + 32'(mul_p_reg[59:30]);
                    n_reg    <= 4'd2;
                end else begin
                    t_reg <= mul_p_reg[59:30];
                end
            end
            ST_E_TF: begin
                term_reg <= 31'(qd_fix);
                mant_reg <= mant_reg + 32'(qd_fix);
                n_reg    <= n_reg + 4'd1;
            end
            ST_W_SH: begin
                fullw_reg <= mul_p_reg >> w_shift;
                total_reg <= '0;
            end
            ST_T_SUM: begin
                total_reg <= total_reg + full_ptr;
                qsum_reg  <= '0;
            end
            ST_B_ADD: base_reg <= base_raw[32] ? CAP32 : base_raw[31:0];
            ST_F_DIV: begin
                if (div_done) begin
                    f_reg <= div_rsp.quot;
                end
            end
            ST_Q_ST: begin
                qv_reg[ptr_reg] <= mul_p_reg[63:8];
                qsum_reg        <= qsum_reg + QSW'(mul_p_reg[63:8]);
            end
            default: begin
                res_prob_reg <= res_prob_reg;
            end
        endcase
    end

    // ---------------------------------------------------------------- output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && (!m_tvalid_reg || m_tready)) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && (!m_tvalid_reg || m_tready)) begin
            out_idx_reg  <= res_idx_reg;
            out_none_reg <= res_none_reg;
            out_prob_reg <= res_prob_reg;
        end
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {6'd0, out_prob_reg, out_idx_reg};
    assign m_tuser[0] = out_none_reg;

    // ---------------------------------------------------------------- checks
    a_no_accept_while_dividing: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_wait_reg)
        else $error("request accepted while a division is in flight");

    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("sequencer did not leave idle after a request transfer");

    a_done_only_when_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> div_wait_reg)
        else $error("divider result with no division outstanding");

    a_none_left_is_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("none_left result carries a non-zero index or probability");

endmodule
